// ===== design/ffts_pkg.sv =====
package ffts_pkg;

  localparam int SLOTS_DEF = 1024;

  localparam int OP_W    = 1;
  localparam int FROM_W  = 10;
  localparam int LEN_W   = 11;
  localparam int OWNER_W = 10;
  localparam int START_W = 10;
  localparam int END_W   = 11;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FROM_W-1:0]  start_from;
    logic [LEN_W-1:0]   run_length;
    logic [OWNER_W-1:0] task_id;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start_slot;
    logic [END_W-1:0]   end_slot;
  } out_item_t;

endpackage

// ===== design/first_fit_time_slot_allocator.sv =====
// Operation: a query scans the slot-owner memory from start_from until it finds a free run
// of run_length slots; allocate mode then writes task_id into each slot of the run. A
// miss scans to the end of the timeline. Zero length returns not-found without a scan.
// One request at a time: the slot-owner memory has one write port and one read port, and
// the block uses them in turn (one read or one write per cycle); in_stall is high meanwhile.
// Reset: a clearing pass writes every slot free, with in_stall held high.
module first_fit_time_slot_allocator
  import ffts_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int ARITH_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]   issue_idx_r, issue_idx_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic               dv_r, dv_nxt;
  logic [LEN_W-1:0]   run_r, run_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [OWNER_W-1:0] task_r, task_nxt;
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [LEN_W-1:0]   wr_left_r, wr_left_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic               out_load;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [OWNER_W-1:0] rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [OWNER_W-1:0] wr_data;

  logic [ARITH_W-1:0] first_a;
  logic [ARITH_W-1:0] end_a;
  logic [ARITH_W-1:0] len_a;

  ffts_ram #(
    .WIDTH (OWNER_W),
    .DEPTH (SLOTS)
  ) u_owner_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign len_a   = ARITH_W'(len_r);
  assign first_a = ARITH_W'(chk_idx_r) + ARITH_W'(1) - len_a;
  assign end_a   = first_a + len_a;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    issue_idx_nxt = issue_idx_r;
    chk_idx_nxt   = chk_idx_r;
    dv_nxt        = 1'b0;
    run_nxt       = run_r;
    op_nxt        = op_r;
    len_nxt       = len_r;
    task_nxt      = task_r;
    wr_idx_nxt    = wr_idx_r;
    wr_left_nxt   = wr_left_r;
    res_nxt       = res_r;
    out_load      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = issue_idx_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = wr_idx_r;
    wr_data       = task_r;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        wr_data     = '0;
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_data.op;
          len_nxt       = in_data.run_length;
          task_nxt      = in_data.task_id;
          issue_idx_nxt = CNT_W'(in_data.start_from);
          run_nxt       = '0;
          if (in_data.run_length == '0 ||
              ARITH_W'(in_data.start_from) >= ARITH_W'(SLOTS)) begin
            res_nxt   = '0;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // keep reads streaming; data returns in the next cycle, tagged by chk_idx
        if (issue_idx_r < CNT_W'(SLOTS)) begin
          rd_en         = 1'b1;
          issue_idx_nxt = issue_idx_r + CNT_W'(1);
        end
        dv_nxt      = rd_en;
        chk_idx_nxt = issue_idx_r[IDX_W-1:0];
        if (dv_r) begin
          if (rd_data == '0) begin
            run_nxt = run_r + LEN_W'(1);
            if (run_r + LEN_W'(1) == len_r) begin
              res_nxt.found      = 1'b1;
              res_nxt.start_slot = first_a[START_W-1:0];
              res_nxt.end_slot   = end_a[END_W-1:0];
              wr_idx_nxt         = first_a[IDX_W-1:0];
              wr_left_nxt        = len_r;
              dv_nxt             = 1'b0;
              state_nxt          = (op_r == OP_ALLOC) ? ST_WRITE : ST_FINISH;
            end
          end else begin
            run_nxt = '0;
          end
        end else if (!rd_en) begin
          // timeline exhausted with no fitting run
          res_nxt   = '0;
          state_nxt = ST_FINISH;
        end
      end

      ST_WRITE: begin
        wr_en       = 1'b1;
        wr_idx_nxt  = wr_idx_r + IDX_W'(1);
        wr_left_nxt = wr_left_r - LEN_W'(1);
        if (wr_left_r == LEN_W'(1)) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // hold the result until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
      out_data_nxt  = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    issue_idx_r <= issue_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    run_r       <= run_nxt;
    op_r        <= op_nxt;
    len_r       <= len_nxt;
    task_r      <= task_nxt;
    wr_idx_r    <= wr_idx_nxt;
    wr_left_r   <= wr_left_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/ffts_ram.sv =====
module ffts_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
